// ===== rtl/core/satr_pkg.sv =====
// shared types and constants of the cache tag and replacement unit
// no dependencies; used by set_assoc_tag_and_replacement and satr_checker
package satr_pkg;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_TOUCH  = 2'd1,
      CMD_FILL   = 2'd2,
      CMD_VICTIM = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [5:0]  set_index;
      logic [19:0] tag;
      logic [1:0]  way;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] result_way;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_COMMIT,
      ST_MOD,
      ST_FINISH
   } state_type;

   // replacement policy codes, the unused code behaves as random
   localparam logic [1:0] MODE_RANDOM = 2'd0;
   localparam logic [1:0] MODE_FIFO   = 2'd1;
   localparam logic [1:0] MODE_LRU    = 2'd2;

   // register file
   localparam int         CSR_INDEX_BITS  = 1;
   localparam int         CSR_DATA_BITS   = 3;
   localparam logic [0:0] CSR_POLICY_MODE = 1'b0;
   localparam logic [0:0] CSR_WAYS_USED   = 1'b1;

   localparam logic [1:0] MODE_RESET      = MODE_LRU;
   localparam logic [2:0] WAYS_USED_RESET = 3'd4;

   localparam logic [15:0] LFSR_TAPS  = 16'hB400;
   localparam logic [15:0] LFSR_RESET = 16'h0001;
   localparam int          LFSR_BITS  = 16;

endpackage

// ===== rtl/core/set_assoc_tag_and_replacement.sv =====
// sequence: lookup and victim (fifo/lru) walk the ways in use through the tag and counter
//   memories; touch under lru adds an aging walk, fill adds one under lru, then a tag commit;
//   random victim reduces the lfsr modulo the ways in use, msb first, without a walk
// throughput: one request at a time; the next request is taken once the response sits in the
//   output register, which waits while an earlier response has not been taken
// reset: synchronous, clears tag and counter valid bits, fill stamp, lfsr, control registers
module set_assoc_tag_and_replacement #(
   parameter int SETS         = 64,
   parameter int WAYS         = 4,
   parameter int TAG_BITS     = 20,
   parameter int COUNTER_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  satr_pkg::req_type                      req_data,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output satr_pkg::rsp_type                      rsp_data,
   // register write port
   input  logic                                   csr_we,
   input  logic [satr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [satr_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int N_BITS   = $clog2(WAYS + 1);
   localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};
   localparam int LFSR_BITS_W = satr_pkg::LFSR_BITS;

   // ---------------------------------------------------------------------------------------------
   // storage: tags and policy counters live in memories, one entry per set and way
   // ---------------------------------------------------------------------------------------------
   logic [TAG_BITS-1:0]     tag_mem [SETS][WAYS];
   logic [COUNTER_BITS-1:0] ctr_mem [SETS][WAYS];
   // tag valid bits and counter valid bits (an unwritten counter reads as zero)
   logic                    vld_ff  [SETS][WAYS];
   logic                    cvld_ff [SETS][WAYS];

   // configuration
   logic [1:0]              mode_ff;
   logic [2:0]              wu_ff;

   // sequencer state
   satr_pkg::state_type     state_ff, state_in;
   logic [N_BITS-1:0]       idx_ff;      // next way to read
   logic                    pend_ff;     // read data of way pway_ff arrives this cycle
   logic [WAY_BITS-1:0]     pway_ff;
   logic [3:0]              bit_ff;      // remainder step counter

   // latched request
   satr_pkg::cmd_type       cmd_ff;
   logic [SET_BITS-1:0]     set_ff;
   logic [TAG_BITS-1:0]     tag_ff;
   logic [WAY_BITS-1:0]     way_ff;

   // scan results
   logic                    found_ff;
   logic [WAY_BITS-1:0]     found_way_ff;
   logic                    touch_hit_ff;
   logic [COUNTER_BITS-1:0] best_ff;
   logic [WAY_BITS-1:0]     best_way_ff;
   logic [N_BITS-1:0]       rem_ff;

   // memory read data
   logic [TAG_BITS-1:0]     tag_q_ff;
   logic [COUNTER_BITS-1:0] ctr_q_ff;
   logic                    vld_q_ff;
   logic                    cvld_q_ff;

   logic [LFSR_BITS_W-1:0]  lfsr_ff;
   logic [COUNTER_BITS-1:0] stamp_ff;

   satr_pkg::rsp_type       rsp_ff;
   logic                    rsp_valid_ff;

   // ---------------------------------------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------------------------------------
   // way field reduced modulo the ways in use (at most three subtractions on a 2-bit value)
   function automatic logic [WAY_BITS-1:0] way_mod(input logic [1:0] w,
                                                   input logic [N_BITS-1:0] n);
      int r;
      r = int'(w);
      for (int i = 0; i < 3; i++) begin
         if (r >= int'(n)) begin
            r = r - int'(n);
         end
      end
      return WAY_BITS'(r);
   endfunction

   // set index reduced modulo SETS through a constant table
   logic [SET_BITS-1:0] set_map [64];
   for (genvar g = 0; g < 64; g++) begin : g_set_map
      assign set_map[g] = SET_BITS'(g % SETS);
   end

   // number of ways in use: zero acts as one, above WAYS acts as WAYS
   logic [N_BITS-1:0] n_cur;
   always_comb begin
      if (wu_ff == 3'd0) begin
         n_cur = N_BITS'(1);
      end else if (int'(wu_ff) > WAYS) begin
         n_cur = N_BITS'(WAYS);
      end else begin
         n_cur = N_BITS'(wu_ff);
      end
   end

   logic is_fifo, is_lru, is_random;
   assign is_fifo   = (mode_ff == satr_pkg::MODE_FIFO);
   assign is_lru    = (mode_ff == satr_pkg::MODE_LRU);
   assign is_random = !is_fifo && !is_lru;

   logic [TAG_BITS+19:0] tag_ext;
   assign tag_ext = {{TAG_BITS{1'b0}}, req_data.tag};

   // galois lfsr, one step per random victim query
   logic [LFSR_BITS_W-1:0] lfsr_next;
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ satr_pkg::LFSR_TAPS) : (lfsr_ff >> 1);

   // ---------------------------------------------------------------------------------------------
   // sequencer control
   // ---------------------------------------------------------------------------------------------
   logic req_fire, issue, walk_done, finish_load;
   logic [WAY_BITS-1:0] rd_way, acc_way;

   assign req_fire  = req_valid && req_ready;
   assign issue     = (idx_ff < n_cur);
   assign walk_done = !issue && !pend_ff;
   assign rd_way    = idx_ff[WAY_BITS-1:0];
   // way that a touch or fill acts on: a fill that finds its tag reuses that way
   assign acc_way   = (cmd_ff == satr_pkg::CMD_FILL && found_ff) ? found_way_ff : way_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         satr_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.command == satr_pkg::CMD_VICTIM && is_random) begin
                  state_in = satr_pkg::ST_MOD;
               end else begin
                  state_in = satr_pkg::ST_SCAN;
               end
            end
         end
         satr_pkg::ST_SCAN: begin
            if (walk_done) begin
               priority if ((cmd_ff == satr_pkg::CMD_TOUCH || cmd_ff == satr_pkg::CMD_FILL)
                            && is_lru) begin
                  state_in = satr_pkg::ST_UPDATE;
               end else if (cmd_ff == satr_pkg::CMD_FILL) begin
                  state_in = satr_pkg::ST_COMMIT;
               end else begin
                  state_in = satr_pkg::ST_FINISH;
               end
            end
         end
         satr_pkg::ST_UPDATE: begin
            if (walk_done) begin
               state_in = (cmd_ff == satr_pkg::CMD_FILL) ? satr_pkg::ST_COMMIT
                                                         : satr_pkg::ST_FINISH;
            end
         end
         satr_pkg::ST_COMMIT: begin
            state_in = satr_pkg::ST_FINISH;
         end
         satr_pkg::ST_MOD: begin
            if (bit_ff == 4'd0) begin
               state_in = satr_pkg::ST_FINISH;
            end
         end
         satr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = satr_pkg::ST_IDLE;
            end
         end
         default: state_in = satr_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   logic                    walking, mem_rd, ctr_we, tag_we;
   logic [WAY_BITS-1:0]     wr_way;
   logic [COUNTER_BITS-1:0] ctr_wd, cur_ctr, aged_ctr;

   assign cur_ctr  = cvld_q_ff ? ctr_q_ff : '0;
   assign aged_ctr = (cur_ctr == CTR_MAX) ? cur_ctr : cur_ctr + COUNTER_BITS'(1);

   always_comb begin
      req_ready   = (state_ff == satr_pkg::ST_IDLE);
      walking     = (state_ff == satr_pkg::ST_SCAN) || (state_ff == satr_pkg::ST_UPDATE);
      mem_rd      = walking && issue;
      finish_load = (state_ff == satr_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      tag_we      = (state_ff == satr_pkg::ST_COMMIT);
      ctr_we      = 1'b0;
      wr_way      = pway_ff;
      ctr_wd      = '0;
      if (state_ff == satr_pkg::ST_UPDATE && pend_ff) begin
         // lru aging: every used way ages, the accessed way restarts at zero
         ctr_we = 1'b1;
         ctr_wd = (pway_ff == acc_way) ? '0 : aged_ctr;
      end else if (state_ff == satr_pkg::ST_COMMIT && is_fifo) begin
         ctr_we = 1'b1;
         wr_way = acc_way;
         ctr_wd = stamp_ff;
      end
   end

   // shared compare unit: fifo keeps the smallest stamp, lru the largest age, ties to lower way
   logic [COUNTER_BITS-1:0] cmp_a, cmp_b;
   logic                    take;
   assign cmp_a = is_fifo ? cur_ctr : best_ff;
   assign cmp_b = is_fifo ? best_ff : cur_ctr;
   assign take  = (pway_ff == '0) || (cmp_a < cmp_b);

   logic tag_match;
   assign tag_match = vld_q_ff && (tag_q_ff == tag_ff);

   // remainder step of lfsr modulo n, msb first
   logic [N_BITS:0] rem_shift, rem_sub;
   assign rem_shift = {rem_ff, lfsr_ff[bit_ff]};
   assign rem_sub   = rem_shift - {1'b0, n_cur};

   // response fields
   logic                 res_hit;
   logic [WAY_BITS-1:0]  res_way;
   logic [WAY_BITS+1:0]  res_way_ext;
   always_comb begin
      unique case (cmd_ff)
         satr_pkg::CMD_LOOKUP: begin
            res_hit = found_ff;
            res_way = found_ff ? found_way_ff : '0;
         end
         satr_pkg::CMD_TOUCH: begin
            res_hit = touch_hit_ff;
            res_way = way_ff;
         end
         satr_pkg::CMD_FILL: begin
            res_hit = found_ff;
            res_way = acc_way;
         end
         satr_pkg::CMD_VICTIM: begin
            res_hit = 1'b0;
            res_way = is_random ? rem_ff[WAY_BITS-1:0] : best_way_ff;
         end
         default: begin
            res_hit = 1'b0;
            res_way = '0;
         end
      endcase
   end
   assign res_way_ext = {2'b00, res_way};

   // ---------------------------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= satr_pkg::ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= satr_pkg::MODE_RESET;
         wu_ff        <= satr_pkg::WAYS_USED_RESET;
         lfsr_ff      <= satr_pkg::LFSR_RESET;
         stamp_ff     <= '0;
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               vld_ff[s][w]  <= 1'b0;
               cvld_ff[s][w] <= 1'b0;
            end
         end
      end else begin
         state_ff <= state_in;

         // configuration writes
         if (csr_we) begin
            unique case (csr_index)
               satr_pkg::CSR_POLICY_MODE: mode_ff <= csr_data[1:0];
               satr_pkg::CSR_WAYS_USED:   wu_ff   <= csr_data;
               default: ;
            endcase
         end

         // way walk pointer
         if (req_fire || (state_ff != state_in && state_in == satr_pkg::ST_UPDATE)) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (walking) begin
            pend_ff <= issue;
            if (issue) begin
               idx_ff <= idx_ff + N_BITS'(1);
            end
         end

         if (req_fire) begin
            bit_ff <= 4'(LFSR_BITS_W - 1);
            if (req_data.command == satr_pkg::CMD_VICTIM && is_random) begin
               lfsr_ff <= lfsr_next;
            end
         end else if (state_ff == satr_pkg::ST_MOD && bit_ff != 4'd0) begin
            bit_ff <= bit_ff - 4'd1;
         end

         if (ctr_we) begin
            cvld_ff[set_ff][wr_way] <= 1'b1;
         end
         if (tag_we) begin
            vld_ff[set_ff][acc_way] <= 1'b1;
            if (is_fifo) begin
               stamp_ff <= stamp_ff + COUNTER_BITS'(1);
            end
         end

         // output register, freed when the response is taken
         if (finish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff       <= req_data.command;
         set_ff       <= set_map[req_data.set_index];
         tag_ff       <= tag_ext[TAG_BITS-1:0];
         way_ff       <= way_mod(req_data.way, n_cur);
         found_ff     <= 1'b0;
         touch_hit_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         // scan: first matching way, touched-way hit, best policy counter
         if (state_ff == satr_pkg::ST_SCAN && pend_ff) begin
            if (tag_match && !found_ff) begin
               found_ff     <= 1'b1;
               found_way_ff <= pway_ff;
            end
            if (pway_ff == way_ff) begin
               touch_hit_ff <= tag_match;
            end
            if (take) begin
               best_ff     <= cur_ctr;
               best_way_ff <= pway_ff;
            end
         end
         if (state_ff == satr_pkg::ST_MOD) begin
            rem_ff <= (rem_shift >= {1'b0, n_cur}) ? rem_sub[N_BITS-1:0]
                                                   : rem_shift[N_BITS-1:0];
         end
      end

      if (mem_rd) begin
         pway_ff   <= rd_way;
         vld_q_ff  <= vld_ff[set_ff][rd_way];
         cvld_q_ff <= cvld_ff[set_ff][rd_way];
      end

      if (finish_load) begin
         rsp_ff.hit        <= res_hit;
         rsp_ff.result_way <= res_way_ext[1:0];
      end
   end

   // tag and counter memories, registered reads
   always_ff @(posedge clock) begin
      if (mem_rd) begin
         tag_q_ff <= tag_mem[set_ff][rd_way];
         ctr_q_ff <= ctr_mem[set_ff][rd_way];
      end
      if (ctr_we) begin
         ctr_mem[set_ff][wr_way] <= ctr_wd;
      end
      if (tag_we) begin
         tag_mem[set_ff][acc_way] <= tag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/satr_checker.sv =====
// port-level checks of the cache tag and replacement unit
// depends on satr_pkg; bound to set_assoc_tag_and_replacement below
module satr_port_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input satr_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input satr_pkg::rsp_type                   rsp_data,
   input logic                                csr_we,
   input logic [satr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [satr_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic       req_fire, rsp_fire;
   logic [1:0] open_ff;   // requests taken whose response is not yet delivered

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         open_ff <= open_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         open_ff <= open_ff - 2'd1;
      end
   end

   // a request keeps the unit busy: ready is low in the cycle after it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request ready right after a request was taken");

   // a response only for a request taken earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an open request");

   // at most one response waiting plus one request in work
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many open requests");

   // a held response does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

endmodule

bind set_assoc_tag_and_replacement satr_port_checker u_satr_port_checker (.*);
